### rtl/voronoi_voxel_check_defines.svh
// Assertion macros for the voxel pair checker.
// Included by the top level; depends on nothing else.
`ifndef VORONOI_VOXEL_CHECK_DEFINES_SVH
`define VORONOI_VOXEL_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VVC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vvc_pkg.sv
// Shared constants and types for the voxel pair checker.
// Used by the configuration register file and the top level; no dependencies.
package vvc_pkg;

    localparam int COORD_BITS = 20;
    localparam int DIST_BITS  = 16;
    localparam int IDX_W      = 3 * COORD_BITS;
    localparam int MODE_W     = 2;
    localparam int L1_SEP_W   = 22;
    localparam int COS_W      = 16;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Datapath widths
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int NORM_W   = SQ_W + 2;
    localparam int DOT_W    = NORM_W + 1;
    localparam int HALF_W   = NORM_W / 2;
    localparam int PROD_W   = 2 * NORM_W;
    localparam int NCHUNK   = PROD_W / HALF_W;
    localparam int C2_W     = 2 * COS_W - 1;
    localparam int SHIFT_W  = 2 * (COS_W - 1);
    localparam int CMP_W    = PROD_W + C2_W;
    localparam int L1_W     = COORD_BITS + 2;
    localparam int L1_CMP_W = (L1_W > L1_SEP_W) ? L1_W : L1_SEP_W;

    typedef enum logic [APB_AW-3:0] {
        REG_MIN_DIST = 2'd0,
        REG_MODE     = 2'd1,
        REG_L1_SEP   = 2'd2,
        REG_COS_SEP  = 2'd3
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_ANGLE  = 2'd0,
        MODE_L1     = 2'd1,
        MODE_EITHER = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [DIST_BITS-1:0] min_distance;
        logic        [MODE_W-1:0]    mode;
        logic        [L1_SEP_W-1:0]  l1_sep;
        logic signed [COS_W-1:0]     cos_sep;
    } t_cfg;

endpackage

### rtl/voronoi_voxel_check.sv
// Voronoi boundary check for one adjacent voxel pair.
//
// Request channel: i_valid / o_ready carry one voxel pair (two signed Q8.8
// distances, two voxel indices, two parent indices). Result channel:
// o_valid / i_ready carry the two Voronoi flags. A request is taken when
// valid and ready are both high on a rising clock edge.
// Throughput: one pair per clock while the result channel is not stalled.
// The pipeline has eight registers (differences, squares, sums, split
// 42x42 products, product assembly, cosine-threshold products, final sum,
// compare and output register).
// When the receiver stalls with a result pending, the whole pipeline holds
// and o_ready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the
// registers with min_distance 0, mode L1-or-angle, both separations 0.
// Configuration: APB-style port, registers at 0x0, 0x4, 0x8, 0xC, pready
// tied high; write only while no request is in flight.
// Depends on vvc_pkg, vvc_cfg_regs and voronoi_voxel_check_defines.svh.
`include "voronoi_voxel_check_defines.svh"

module voronoi_voxel_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vvc_pkg::APB_AW-1:0]          paddr,
    input  logic [vvc_pkg::APB_DW-1:0]          pwdata,
    output logic [vvc_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [vvc_pkg::DIST_BITS-1:0] i_current_distance,
    input  logic signed [vvc_pkg::DIST_BITS-1:0] i_neighbor_distance,
    input  logic [vvc_pkg::IDX_W-1:0]           i_current_index,
    input  logic [vvc_pkg::IDX_W-1:0]           i_neighbor_index,
    input  logic [vvc_pkg::IDX_W-1:0]           i_current_parent,
    input  logic [vvc_pkg::IDX_W-1:0]           i_neighbor_parent,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_current_is_voronoi,
    output logic                                o_neighbor_is_voronoi
);
    import vvc_pkg::*;

    localparam int NSTAGE = 8;

    typedef struct packed {
        logic rej;
        logic l1_uniq;
        logic cur_le;
        logic nbr_le;
        logic ang_done;
        logic ang_early;
        logic d_pos;
    } t_flags;

    function automatic logic signed [COORD_BITS-1:0] coord(
        input logic [IDX_W-1:0] v,
        input int               k
    );
        coord = v[k*COORD_BITS +: COORD_BITS];
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y
    );
        diff = DIFF_W'(x) - DIFF_W'(y);
    endfunction

    function automatic logic [COORD_BITS-1:0] absmag(input logic signed [DIFF_W-1:0] x);
        logic [DIFF_W-1:0] m;
        m      = x[DIFF_W-1] ? (~x + 1'b1) : x;
        absmag = m[COORD_BITS-1:0];
    endfunction

    t_cfg w_cfg;

    vvc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;

    // Pipeline control: every stage moves together unless the output is stuck
    logic [NSTAGE-1:0] r_vld;
    logic              adv;

    assign adv     = !r_vld[NSTAGE-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    // Stage 1: coordinate differences, distance rejection
    logic signed [DIFF_W-1:0]     n1_a [3], n1_b [3], n1_u [3], n1_v [3];
    logic        [COORD_BITS-1:0] n1_p [3];
    t_flags                       n1_f;
    logic signed [DIFF_W-1:0]     r1_a [3], r1_b [3], r1_u [3], r1_v [3];
    logic        [COORD_BITS-1:0] r1_p [3];
    t_flags                       r1_f;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_a[k] = diff(coord(i_current_parent, k), coord(i_current_index, k));
            n1_b[k] = diff(coord(i_neighbor_parent, k), coord(i_current_index, k));
            n1_u[k] = diff(coord(i_current_index, k), coord(i_neighbor_parent, k));
            n1_v[k] = diff(coord(i_neighbor_index, k), coord(i_current_parent, k));
            n1_p[k] = absmag(diff(coord(i_current_parent, k),
                                  coord(i_neighbor_parent, k)));
        end
        n1_f     = '0;
        n1_f.rej = (i_current_distance <= w_cfg.min_distance) ||
                   (i_neighbor_distance <= w_cfg.min_distance);
    end

    // Stage 2: per-axis squares and dot terms, L1 test
    logic        [SQ_W-1:0]       n2_aa [3], n2_bb [3], n2_uu [3], n2_vv [3];
    logic signed [2*DIFF_W-1:0]   n2_ab [3];
    logic        [L1_CMP_W-1:0]   n2_l1;
    t_flags                       n2_f;
    logic        [SQ_W-1:0]       r2_aa [3], r2_bb [3], r2_uu [3], r2_vv [3];
    logic signed [2*DIFF_W-1:0]   r2_ab [3];
    t_flags                       r2_f;

    always_comb begin
        n2_l1 = '0;
        for (int k = 0; k < 3; k++) begin
            n2_aa[k] = SQ_W'(r1_a[k] * r1_a[k]);
            n2_bb[k] = SQ_W'(r1_b[k] * r1_b[k]);
            n2_uu[k] = SQ_W'(r1_u[k] * r1_u[k]);
            n2_vv[k] = SQ_W'(r1_v[k] * r1_v[k]);
            n2_ab[k] = r1_a[k] * r1_b[k];
            n2_l1    = n2_l1 + L1_CMP_W'(r1_p[k]);
        end
        n2_f         = r1_f;
        n2_f.l1_uniq = n2_l1 > L1_CMP_W'(w_cfg.l1_sep);
    end

    // Stage 3: norms, dot product, Voronoi compare, early angle decision
    logic        [NORM_W-1:0] n3_na, n3_nb, n3_dc, n3_dn, n3_dabs;
    logic signed [DOT_W-1:0]  n3_d;
    logic                     n3_dneg, n3_dzero, n3_cpos;
    t_flags                   n3_f;
    logic        [NORM_W-1:0] r3_na, r3_nb, r3_dabs;
    t_flags                   r3_f;

    always_comb begin
        n3_na = '0;
        n3_nb = '0;
        n3_dc = '0;
        n3_dn = '0;
        n3_d  = '0;
        for (int k = 0; k < 3; k++) begin
            n3_na = n3_na + NORM_W'(r2_aa[k]);
            n3_nb = n3_nb + NORM_W'(r2_bb[k]);
            n3_dc = n3_dc + NORM_W'(r2_uu[k]);
            n3_dn = n3_dn + NORM_W'(r2_vv[k]);
            n3_d  = n3_d + DOT_W'(r2_ab[k]);
        end
        n3_dneg  = n3_d[DOT_W-1];
        n3_dzero = (n3_d == '0);
        n3_dabs  = n3_dneg ? NORM_W'(-n3_d) : NORM_W'(n3_d);
        n3_cpos  = !w_cfg.cos_sep[COS_W-1] && (w_cfg.cos_sep != '0);

        n3_f        = r2_f;
        n3_f.cur_le = n3_dc <= n3_dn;
        n3_f.nbr_le = n3_dn <= n3_dc;
        n3_f.d_pos  = !n3_dneg && !n3_dzero;
        // zero vector counts as cosine 0; opposite signs settle without squares
        if ((n3_na == '0) || (n3_nb == '0)) begin
            n3_f.ang_done  = 1'b1;
            n3_f.ang_early = n3_cpos;
        end else if (n3_cpos && !n3_f.d_pos) begin
            n3_f.ang_done  = 1'b1;
            n3_f.ang_early = 1'b1;
        end else if (!n3_cpos && !n3_dneg) begin
            n3_f.ang_done  = 1'b1;
            n3_f.ang_early = 1'b0;
        end else begin
            n3_f.ang_done  = 1'b0;
            n3_f.ang_early = 1'b0;
        end
    end

    // Stage 4: split products for d^2 and na*nb
    logic [2*HALF_W-1:0] r4_dll, r4_dlh, r4_dhh;
    logic [2*HALF_W-1:0] r4_nll, r4_nlh, r4_nhl, r4_nhh;
    t_flags              r4_f;
    logic [HALF_W-1:0]   w4_dl, w4_dh, w4_al, w4_ah, w4_bl, w4_bh;

    assign w4_dl = r3_dabs[HALF_W-1:0];
    assign w4_dh = r3_dabs[NORM_W-1:HALF_W];
    assign w4_al = r3_na[HALF_W-1:0];
    assign w4_ah = r3_na[NORM_W-1:HALF_W];
    assign w4_bl = r3_nb[HALF_W-1:0];
    assign w4_bh = r3_nb[NORM_W-1:HALF_W];

    // Stage 5: assemble products, square the cosine threshold
    logic [PROD_W-1:0]        n5_dsq, n5_nn;
    logic signed [2*COS_W-1:0] n5_csq;
    logic [PROD_W-1:0]        r5_dsq, r5_nn;
    logic [C2_W-1:0]          r5_c2;
    t_flags                   r5_f;

    always_comb begin
        n5_dsq = (PROD_W'(r4_dhh) << (2*HALF_W)) + (PROD_W'(r4_dlh) << (HALF_W+1))
               + PROD_W'(r4_dll);
        n5_nn  = (PROD_W'(r4_nhh) << (2*HALF_W)) + (PROD_W'(r4_nlh) << HALF_W)
               + (PROD_W'(r4_nhl) << HALF_W) + PROD_W'(r4_nll);
        n5_csq = w_cfg.cos_sep * w_cfg.cos_sep;
    end

    // Stage 6: chunked products of na*nb with c^2
    logic [HALF_W+C2_W-1:0] r6_pp [NCHUNK];
    logic [PROD_W-1:0]      r6_dsq;
    t_flags                 r6_f;

    // Stage 7: assemble both sides of the squared cosine compare
    logic [CMP_W-1:0] n7_rhs;
    logic [CMP_W-1:0] r7_lhs, r7_rhs;
    t_flags           r7_f;

    always_comb begin
        n7_rhs = '0;
        for (int k = 0; k < NCHUNK; k++) begin
            n7_rhs = n7_rhs + (CMP_W'(r6_pp[k]) << (k*HALF_W));
        end
    end

    // Stage 8: angle decision, mode select, output register
    logic n8_ang, n8_uniq, n8_ok;
    logic r8_cur, r8_nbr, r8_rej, r8_ok;

    always_comb begin
        if (r7_f.ang_done) begin
            n8_ang = r7_f.ang_early;
        end else if (r7_f.d_pos) begin
            n8_ang = r7_lhs < r7_rhs;
        end else begin
            n8_ang = r7_rhs < r7_lhs;
        end
        case (w_cfg.mode)
            MODE_ANGLE: n8_uniq = n8_ang;
            MODE_L1:    n8_uniq = r7_f.l1_uniq;
            default:    n8_uniq = r7_f.l1_uniq || n8_ang;
        endcase
        n8_ok = !r7_f.rej && n8_uniq;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a <= n1_a;
            r1_b <= n1_b;
            r1_u <= n1_u;
            r1_v <= n1_v;
            r1_p <= n1_p;
            r1_f <= n1_f;

            r2_aa <= n2_aa;
            r2_bb <= n2_bb;
            r2_uu <= n2_uu;
            r2_vv <= n2_vv;
            r2_ab <= n2_ab;
            r2_f  <= n2_f;

            r3_na   <= n3_na;
            r3_nb   <= n3_nb;
            r3_dabs <= n3_dabs;
            r3_f    <= n3_f;

            r4_dll <= w4_dl * w4_dl;
            r4_dlh <= w4_dl * w4_dh;
            r4_dhh <= w4_dh * w4_dh;
            r4_nll <= w4_al * w4_bl;
            r4_nlh <= w4_al * w4_bh;
            r4_nhl <= w4_ah * w4_bl;
            r4_nhh <= w4_ah * w4_bh;
            r4_f   <= r3_f;

            r5_dsq <= n5_dsq;
            r5_nn  <= n5_nn;
            r5_c2  <= n5_csq[C2_W-1:0];
            r5_f   <= r4_f;

            for (int k = 0; k < NCHUNK; k++) begin
                r6_pp[k] <= r5_nn[k*HALF_W +: HALF_W] * r5_c2;
            end
            r6_dsq <= r5_dsq;
            r6_f   <= r5_f;

            r7_lhs <= CMP_W'(r6_dsq) << SHIFT_W;
            r7_rhs <= n7_rhs;
            r7_f   <= r6_f;

            r8_cur <= n8_ok && r7_f.cur_le;
            r8_nbr <= n8_ok && r7_f.nbr_le;
            r8_rej <= r7_f.rej;
            r8_ok  <= n8_ok;
        end
    end

    assign o_current_is_voronoi  = r8_cur;
    assign o_neighbor_is_voronoi = r8_nbr;

    `VVC_ASSERT(a_reject_clears, i_clk, i_rst_n, o_valid && r8_rej, !o_current_is_voronoi && !o_neighbor_is_voronoi, "rejected pair has a flag set")
    `VVC_ASSERT(a_accept_one_side, i_clk, i_rst_n, o_valid && r8_ok, o_current_is_voronoi || o_neighbor_is_voronoi, "accepted pair has no Voronoi side")
    `VVC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !adv, $stable(r_vld), "pipeline moved while stalled")
    `VVC_ASSERT_NEXT(a_request_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0], "accepted request lost at entry")

endmodule

### rtl/vvc_cfg_regs.sv
// APB-style configuration register file for the voxel pair checker.
// Depends on vvc_pkg for register indexes and the t_cfg bundle.
module vvc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vvc_pkg::APB_AW-1:0]  paddr,
    input  logic [vvc_pkg::APB_DW-1:0]  pwdata,
    output logic [vvc_pkg::APB_DW-1:0]  prdata,
    output vvc_pkg::t_cfg               o_cfg
);
    import vvc_pkg::*;

    t_cfg     r_cfg;
    logic     w_en;
    t_reg_idx w_idx;

    assign w_en  = psel && penable && pwrite;
    assign w_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance <= '0;
            r_cfg.mode         <= MODE_EITHER;
            r_cfg.l1_sep       <= '0;
            r_cfg.cos_sep      <= '0;
        end else if (w_en) begin
            case (w_idx)
                REG_MIN_DIST: r_cfg.min_distance <= pwdata[DIST_BITS-1:0];
                REG_MODE:     r_cfg.mode         <= pwdata[MODE_W-1:0];
                REG_L1_SEP:   r_cfg.l1_sep       <= pwdata[L1_SEP_W-1:0];
                REG_COS_SEP:  r_cfg.cos_sep      <= pwdata[COS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_MIN_DIST: prdata[DIST_BITS-1:0] = r_cfg.min_distance;
            REG_MODE:     prdata[MODE_W-1:0]    = r_cfg.mode;
            REG_L1_SEP:   prdata[L1_SEP_W-1:0]  = r_cfg.l1_sep;
            REG_COS_SEP:  prdata[COS_W-1:0]     = r_cfg.cos_sep;
            default:      prdata = '0;
        endcase
    end

endmodule
